[rtl/scva_pkg.sv]
// Shared constants, register indexes and lane result type for the
// stacked cell voltage averager. No dependencies.
package scva_pkg;

   localparam int NUM_TAPS             = 3;
   localparam int SAMPLE_W             = 12;
   localparam int GAIN_W               = 16;
   localparam int OFFSET_W             = 16;
   localparam int MV_W                 = 18;
   localparam int DEFAULT_WINDOW_DEPTH = 8;

   localparam int               MV_SCALE_W = 12;
   localparam logic [MV_SCALE_W-1:0] MV_SCALE = 12'd3300;
   localparam int               FRAC_SHIFT = 24;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_TAP1   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_TAP2   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_TAP3   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_TAP1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_TAP2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_TAP3 = 3'd5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic                   valid;
      logic signed [MV_W-1:0] mv;
   } lane_out_type;

endpackage

[rtl/scva_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module scva_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scva_lane.sv]
// One tap lane: sample window in RAM, running sum, average by reciprocal
// multiply, millivolt scaling, gain and offset. Uses scva_pkg and scva_ram.
module scva_lane #(
   parameter int WINDOW_DEPTH = scva_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                take,
   input  logic [scva_pkg::SAMPLE_W-1:0]       sample,
   input  logic [scva_pkg::GAIN_W-1:0]         gain,
   input  logic signed [scva_pkg::OFFSET_W-1:0] offset,
   output scva_pkg::lane_out_type              result
);

   localparam int SAMPLE_W = scva_pkg::SAMPLE_W;
   localparam int MV_W     = scva_pkg::MV_W;
   localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int SCALED_W = SAMPLE_W + scva_pkg::MV_SCALE_W;
   localparam int GPROD_W  = SCALED_W + scva_pkg::GAIN_W;
   localparam int STAGES   = 7;

   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << SUM_W) / WINDOW_DEPTH);
   localparam logic [SUM_W-1:0]   DEPTH_C   = SUM_W'(WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   logic [STAGES-1:0]      stage_ff;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   res_valid_ff, res_valid_in;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SAMPLE_W-1:0]    avg_ff, avg_in;
   logic [SCALED_W-1:0]    scaled_ff, scaled_in;
   logic [GPROD_W-1:0]     gprod_ff, gprod_in;
   logic signed [MV_W-1:0] mv_ff, mv_in;

   logic [SAMPLE_W-1:0]    rd_data;
   logic [SAMPLE_W-1:0]    oldest;
   logic [SUM_W-1:0]       quot;
   logic [SUM_W-1:0]       quot_depth;
   logic [SUM_W-1:0]       rem;

   scva_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (stage_ff[1]),
      .wr_addr(slot_ff),
      .wr_data(sample_ff),
      .rd_en  (stage_ff[0]),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      oldest     = wrapped_ff ? rd_data : '0;
      sum_in     = sum_ff;
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (stage_ff[1]) begin
         sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample_ff);
         if (slot_ff == LAST_SLOT) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end

      prod_in    = PROD_W'(sum_ff) * PROD_W'(RECIP);
      quot       = prod_ff[SUM_W +: SUM_W];
      quot_depth = SUM_W'(quot * DEPTH_C);
      rem        = sum_ff - quot_depth;
      avg_in     = quot[SAMPLE_W-1:0] + SAMPLE_W'(rem >= DEPTH_C);
      scaled_in  = SCALED_W'(avg_ff) * SCALED_W'(scva_pkg::MV_SCALE);
      gprod_in   = GPROD_W'(scaled_ff) * GPROD_W'(gain);
      mv_in      = MV_W'(gprod_ff[GPROD_W-1:scva_pkg::FRAC_SHIFT]) + MV_W'(offset);

      res_valid_in = res_valid_ff;
      if (take) begin
         res_valid_in = 1'b0;
      end
      if (stage_ff[STAGES-1]) begin
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= '0;
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= {stage_ff[STAGES-2:0], start};
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sample_ff <= sample;
      end
      if (stage_ff[2]) begin
         prod_ff <= prod_in;
      end
      if (stage_ff[3]) begin
         avg_ff <= avg_in;
      end
      if (stage_ff[4]) begin
         scaled_ff <= scaled_in;
      end
      if (stage_ff[5]) begin
         gprod_ff <= gprod_in;
      end
      if (stage_ff[6]) begin
         mv_ff <= mv_in;
      end
   end

   assign result.valid = res_valid_ff;
   assign result.mv    = mv_ff;

endmodule

[rtl/scva_merge.sv]
// Merge stage: turns the three tap voltages into cell voltages and holds
// the result item for the output channel. Uses scva_pkg.
module scva_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  scva_pkg::lane_out_type              lanes [scva_pkg::NUM_TAPS],
   output logic                                take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scva_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int MV_W   = scva_pkg::MV_W;
   localparam int WIDE_W = MV_W + 2;
   localparam int PAD_W  = scva_pkg::RSP_DATA_W - 3 * MV_W;

   localparam logic signed [WIDE_W-1:0] MV_MAX = WIDE_W'((1 << (MV_W - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] MV_MIN = -WIDE_W'(1 << (MV_W - 1));

   function automatic logic [MV_W-1:0] sat_mv(input logic signed [WIDE_W-1:0] x);
      logic [MV_W-1:0] r;
      if (x > MV_MAX) begin
         r = MV_MAX[MV_W-1:0];
      end else if (x < MV_MIN) begin
         r = MV_MIN[MV_W-1:0];
      end else begin
         r = x[MV_W-1:0];
      end
      return r;
   endfunction

   logic signed [WIDE_W-1:0]           v1, v2, v3, cell1, cell2, cell3;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [scva_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   always_comb begin
      v1    = WIDE_W'(lanes[0].mv);
      v2    = WIDE_W'(lanes[1].mv);
      v3    = WIDE_W'(lanes[2].mv);
      cell3 = v3;
      cell2 = v2 - cell3;
      cell1 = v1 - cell2 - cell3;
      take  = lanes[0].valid && lanes[1].valid && lanes[2].valid
              && (!rsp_valid_ff || rsp_tready);
      rsp_data_in  = {{PAD_W{1'b0}}, sat_mv(cell3), sat_mv(cell2), sat_mv(cell1)};
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/stacked_cell_voltage_averager.sv]
// Top level of the stacked cell voltage averager: register block, three tap
// lanes and the merge stage. Uses scva_pkg, scva_lane and scva_merge.
//
// Each item carries one ADC code per stack tap; it yields one item with the
// three cell voltages in millivolts. The block works on one item at a time:
// an item goes through the seven-stage lane pipeline (window RAM read, sum
// update, reciprocal multiply, remainder correction, millivolt scale, gain
// multiply, offset add) into the lane result registers, and the next item is
// taken the cycle after that result leaves the lanes. The output register
// lets a new item start while the previous result waits. No clearing pass
// is needed after reset: the windows count as zero until first filled.
module stacked_cell_voltage_averager #(
   parameter int WINDOW_DEPTH = scva_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_tap1, sample_tap2, sample_tap3, zero pad
   input  logic [scva_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cell1_mv, cell2_mv, cell3_mv, zero pad
   output logic [scva_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [scva_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scva_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NUM_TAPS = scva_pkg::NUM_TAPS;
   localparam int SAMPLE_W = scva_pkg::SAMPLE_W;

   logic [scva_pkg::GAIN_W-1:0]          gain_ff   [NUM_TAPS];
   logic signed [scva_pkg::OFFSET_W-1:0] offset_ff [NUM_TAPS];
   logic                                 busy_ff, busy_in;
   logic                                 accept;
   logic                                 take;
   scva_pkg::lane_out_type               lane_out [NUM_TAPS];

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      if (take) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         for (int t = 0; t < NUM_TAPS; t++) begin
            gain_ff[t]   <= scva_pkg::GAIN_RESET;
            offset_ff[t] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         if (csr_wr_en) begin
            case (csr_index)
               scva_pkg::REG_GAIN_TAP1:   gain_ff[0]   <= csr_wdata;
               scva_pkg::REG_GAIN_TAP2:   gain_ff[1]   <= csr_wdata;
               scva_pkg::REG_GAIN_TAP3:   gain_ff[2]   <= csr_wdata;
               scva_pkg::REG_OFFSET_TAP1: offset_ff[0] <= csr_wdata;
               scva_pkg::REG_OFFSET_TAP2: offset_ff[1] <= csr_wdata;
               scva_pkg::REG_OFFSET_TAP3: offset_ff[2] <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_lane
      scva_lane #(
         .WINDOW_DEPTH(WINDOW_DEPTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .start (accept),
         .take  (take),
         .sample(req_tdata[t*SAMPLE_W +: SAMPLE_W]),
         .gain  (gain_ff[t]),
         .offset(offset_ff[t]),
         .result(lane_out[t])
      );
   end

   scva_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lane_out),
      .take      (take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (lane_out[0].valid == lane_out[1].valid) && (lane_out[1].valid == lane_out[2].valid))
      else $error("tap lanes out of step");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> busy_ff)
      else $error("result taken with no item in flight");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      accept |-> !lane_out[0].valid)
      else $error("item accepted while a lane result is pending");

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("taken result not presented");
`endif

endmodule

[sim/scva_checker.sv]
// Checker for the stacked cell voltage averager: tracks register writes,
// predicts the three cell voltages of each accepted item and compares them
// with the result stream in order. Depends on scva_pkg.
module scva_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [scva_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [scva_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [scva_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scva_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               cells_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TAPS = scva_pkg::NUM_TAPS;
   localparam int SAMPLE_W = scva_pkg::SAMPLE_W;
   localparam int MV_W     = scva_pkg::MV_W;
   localparam int DEPTH    = scva_pkg::DEFAULT_WINDOW_DEPTH;
   localparam int SUM_W    = SAMPLE_W + $clog2(DEPTH);
   localparam longint MV_MAX = 131071;
   localparam longint MV_MIN = -131072;

   typedef struct packed {
      logic signed [MV_W-1:0] cell3;
      logic signed [MV_W-1:0] cell2;
      logic signed [MV_W-1:0] cell1;
   } cells_type;

   logic [SAMPLE_W-1:0]                  window [NUM_TAPS][DEPTH];
   logic [SUM_W-1:0]                     window_sum [NUM_TAPS];
   int                                   next_slot;
   logic [scva_pkg::GAIN_W-1:0]          gain [NUM_TAPS];
   logic signed [scva_pkg::OFFSET_W-1:0] offset [NUM_TAPS];
   cells_type                            cells_due [$];
   int                                   errors;

   initial begin
      errors = 0;
      mismatches = 0;
      cells_pending = 0;
   end

   function automatic void clear_state();
      for (int t = 0; t < NUM_TAPS; t++) begin
         for (int i = 0; i < DEPTH; i++) window[t][i] = '0;
         window_sum[t] = '0;
         gain[t] = scva_pkg::GAIN_RESET;
         offset[t] = '0;
      end
      next_slot = 0;
   endfunction

   function automatic void apply_write(logic [scva_pkg::CSR_INDEX_W-1:0] idx,
                                       logic [scva_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         scva_pkg::REG_GAIN_TAP1: gain[0] = data;
         scva_pkg::REG_GAIN_TAP2: gain[1] = data;
         scva_pkg::REG_GAIN_TAP3: gain[2] = data;
         scva_pkg::REG_OFFSET_TAP1: offset[0] = data;
         scva_pkg::REG_OFFSET_TAP2: offset[1] = data;
         scva_pkg::REG_OFFSET_TAP3: offset[2] = data;
         default: ;
      endcase
   endfunction

   function automatic longint tap_millivolts(int t);
      longint avg;
      longint scaled;
      avg = longint'(window_sum[t]) / DEPTH;
      scaled = (avg * longint'(scva_pkg::MV_SCALE) * longint'(gain[t]))
               >>> scva_pkg::FRAC_SHIFT;
      return scaled + longint'(offset[t]);
   endfunction

   function automatic logic signed [MV_W-1:0] clamp_mv(longint x);
      if (x > MV_MAX) x = MV_MAX;
      if (x < MV_MIN) x = MV_MIN;
      return x[MV_W-1:0];
   endfunction

   function automatic cells_type predict_cells(logic [scva_pkg::REQ_DATA_W-1:0] data);
      logic [SAMPLE_W-1:0] s;
      longint              v [NUM_TAPS];
      cells_type           c;
      for (int t = 0; t < NUM_TAPS; t++) begin
         s = data[t*SAMPLE_W +: SAMPLE_W];
         window_sum[t] = window_sum[t] - window[t][next_slot] + s;
         window[t][next_slot] = s;
      end
      next_slot = (next_slot + 1) % DEPTH;
      for (int t = 0; t < NUM_TAPS; t++) v[t] = tap_millivolts(t);
      c.cell3 = clamp_mv(v[2]);
      c.cell2 = clamp_mv(v[1] - v[2]);
      c.cell1 = clamp_mv(v[0] - (v[1] - v[2]) - v[2]);
      return c;
   endfunction

   always @(posedge clock) begin
      cells_type want;
      cells_type got;
      if (reset) begin
         clear_state();
         cells_due.delete();
      end else begin
         if (csr_wr_en) apply_write(csr_index, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            got = cells_type'(rsp_tdata[3*MV_W-1:0]);
            if (cells_due.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               want = cells_due.pop_front();
               if (got.cell1 !== want.cell1) begin
                  $error("cell1_mv expected %0d got %0d", want.cell1, got.cell1);
                  errors++;
               end
               if (got.cell2 !== want.cell2) begin
                  $error("cell2_mv expected %0d got %0d", want.cell2, got.cell2);
                  errors++;
               end
               if (got.cell3 !== want.cell3) begin
                  $error("cell3_mv expected %0d got %0d", want.cell3, got.cell3);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) cells_due.push_back(predict_cells(req_tdata));
      end
      cells_pending <= cells_due.size();
      mismatches <= errors;
   end

endmodule

[sim/stacked_cell_voltage_averager_test.sv]
// Top of the stacked cell voltage averager testbench: clock, reset, sample
// and register stimulus with random idling, and the verdict. Uses scva_pkg,
// scva_checker and the block itself.
module stacked_cell_voltage_averager_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W    = scva_pkg::SAMPLE_W;
   localparam int GAIN_W      = scva_pkg::GAIN_W;
   localparam int OFFSET_W    = scva_pkg::OFFSET_W;
   localparam int CSR_INDEX_W = scva_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = scva_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W  = scva_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = scva_pkg::RSP_DATA_W;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 3'd7;
   localparam logic [SAMPLE_W-1:0]    CODE_MAX    = 12'hFFF;
   localparam int                     PHASE_ITEMS = 204;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     mismatches;
   int                     cells_pending;
   int unsigned            cycle_count = 0;
   bit                     steady_sender = 1'b0;

   stacked_cell_voltage_averager uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scva_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .cells_pending (cells_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_code();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return CODE_MAX;
      return SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   task automatic send_item(logic [SAMPLE_W-1:0] t1, logic [SAMPLE_W-1:0] t2,
                            logic [SAMPLE_W-1:0] t3);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {{(REQ_DATA_W - 3*SAMPLE_W){1'b0}}, t3, t2, t1};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic stream_random(int count);
      repeat (count) send_item(pick_code(), pick_code(), pick_code());
   endtask

   task automatic settle();
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(logic [GAIN_W-1:0] g1, logic [GAIN_W-1:0] g2,
                                logic [GAIN_W-1:0] g3, logic [OFFSET_W-1:0] o1,
                                logic [OFFSET_W-1:0] o2, logic [OFFSET_W-1:0] o3,
                                bit touch_spares);
      req_tvalid <= 1'b0;
      settle();
      write_reg(scva_pkg::REG_GAIN_TAP1, g1);
      write_reg(scva_pkg::REG_GAIN_TAP2, g2);
      write_reg(scva_pkg::REG_GAIN_TAP3, g3);
      write_reg(scva_pkg::REG_OFFSET_TAP1, o1);
      write_reg(scva_pkg::REG_OFFSET_TAP2, o2);
      write_reg(scva_pkg::REG_OFFSET_TAP3, o3);
      if (touch_spares) begin
         write_reg(REG_SPARE_A, CSR_DATA_W'($urandom));
         write_reg(REG_SPARE_B, CSR_DATA_W'($urandom));
      end
      csr_wr_en <= 1'b0;
   endtask

   // result side: random backpressure, one long hold-off to fill the pipeline
   initial begin : result_sink
      int gap;
      bit held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && cycle_count >= 2000) begin
            held_off = 1'b1;
            gap = 400;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 12))
            @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fresh windows, full-scale fill, single taps, decay
      send_item('0, '0, '0);
      repeat (9) send_item(CODE_MAX, CODE_MAX, CODE_MAX);
      send_item(CODE_MAX, '0, '0);
      send_item('0, CODE_MAX, '0);
      send_item('0, '0, CODE_MAX);
      repeat (8) send_item('0, '0, '0);
      send_item(12'd1, 12'd2048, 12'd4094);
      stream_random(PHASE_ITEMS);

      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      stream_random(PHASE_ITEMS);

      steady_sender = 1'b1;
      load_settings(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      stream_random(PHASE_ITEMS);
      steady_sender = 1'b0;

      load_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                    OFFSET_W'($urandom), OFFSET_W'($urandom), OFFSET_W'($urandom), 1'b1);
      stream_random(PHASE_ITEMS);

      load_settings(16'hFFFF, scva_pkg::GAIN_RESET, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000,
                    1'b0);
      stream_random(PHASE_ITEMS);

      load_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                    OFFSET_W'($urandom), OFFSET_W'($urandom), OFFSET_W'($urandom), 1'b1);
      stream_random(PHASE_ITEMS);

      load_settings(scva_pkg::GAIN_RESET, scva_pkg::GAIN_RESET, scva_pkg::GAIN_RESET,
                    '0, '0, '0, 1'b0);
      stream_random(PHASE_ITEMS);

      req_tvalid <= 1'b0;
      settle();
      if (mismatches == 0 && cells_pending == 0)
         $display("stacked_cell_voltage_averager verification clean");
      else
         $display("stacked_cell_voltage_averager verification failed");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("stacked_cell_voltage_averager verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/scva_pkg.sv
rtl/scva_ram.sv
rtl/scva_lane.sv
rtl/scva_merge.sv
rtl/stacked_cell_voltage_averager.sv
sim/scva_checker.sv
sim/stacked_cell_voltage_averager_test.sv
